### sv/vidc_pkg.sv
package vidc_pkg;

    localparam int unsigned VecW   = 32;
    localparam int unsigned DtW    = 16;
    localparam int unsigned DragW  = 24;
    localparam int unsigned MaxW   = 31;
    localparam int unsigned FuncW  = 2;
    localparam int unsigned IdxW   = 1;
    localparam int unsigned CfgW   = 31;

    localparam logic [63:0] EpsSq = 64'd429497;

    typedef enum logic [FuncW-1:0] {
        FUNC_ADD_FORCE = 2'd0,
        FUNC_TICK      = 2'd1,
        FUNC_SET_VEL   = 2'd2,
        FUNC_NONE      = 2'd3
    } t_func;

    localparam logic [IdxW-1:0] REG_DRAG = 1'b0;
    localparam logic [IdxW-1:0] REG_MAX  = 1'b1;

    typedef struct packed {
        logic [FuncW-1:0]       func;
        logic signed [VecW-1:0] vec_x;
        logic signed [VecW-1:0] vec_y;
        logic signed [VecW-1:0] vec_z;
        logic [DtW-1:0]         time_step;
    } t_in;

    typedef struct packed {
        logic signed [VecW-1:0] vel_x;
        logic signed [VecW-1:0] vel_y;
        logic signed [VecW-1:0] vel_z;
        logic signed [VecW-1:0] move_x;
        logic signed [VecW-1:0] move_y;
        logic signed [VecW-1:0] move_z;
        logic                   moved;
    } t_out;

    // Commands to the shared divide/square-root unit.
    typedef struct packed {
        logic        start;
        logic        is_sqrt;
        logic [63:0] num;
        logic [32:0] den;
    } t_dreq;

    typedef struct packed {
        logic        done;
        logic [32:0] res;
    } t_dres;

endpackage

### sv/vidc_if.sv
interface vidc_in_if;
    logic          valid;
    logic          ready;
    vidc_pkg::t_in data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface vidc_out_if;
    logic           valid;
    logic           ready;
    vidc_pkg::t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### sv/velocity_integrator_drag_clamp.sv
// Velocity integrator with linear drag and a speed clamp. The block holds a
// signed Q16.16 velocity and force accumulator per axis. Every accepted
// transfer yields exactly one result transfer. An add-force, set-velocity or
// unused-selector item goes from idle through the output and wait states. A
// tick runs a small sequencer around one shared 33 x 33 bit multiplier, one
// product per cycle except while waiting. A tick whose squared speed is at
// most the cut-off zeroes the velocity and skips the displacement products.
// When the speed clamp applies, a square root and three divisions run on the
// shared bit-serial unit. The input is not ready while an item is in work or
// its result waits. Configuration should only be written while the block is idle.
module velocity_integrator_drag_clamp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [vidc_pkg::IdxW-1:0]  i_cfg_idx,
    input  logic [vidc_pkg::CfgW-1:0]  i_cfg_data,
    vidc_in_if.sink                    s_in,
    vidc_out_if.source                 m_out
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_FMUL  = 11'b00000000010,
        S_DRAG  = 11'b00000000100,
        S_DMUL  = 11'b00000001000,
        S_SQ    = 11'b00000010000,
        S_TEST  = 11'b00000100000,
        S_SQRT  = 11'b00001000000,
        S_DIV   = 11'b00010000000,
        S_MMUL  = 11'b00100000000,
        S_OUT   = 11'b01000000000,
        S_WAIT  = 11'b10000000000
    } t_state;

    t_state r_state;
    logic [vidc_pkg::DragW-1:0] r_drag;
    logic [vidc_pkg::MaxW-1:0]  r_max;
    logic signed [31:0] r_vel [3];
    logic signed [31:0] r_frc [3];
    logic signed [31:0] r_mv  [3];
    logic [15:0] r_dt;
    logic [1:0]  r_ax;
    logic [1:0]  r_ph;
    logic [32:0] r_mult;
    logic [65:0] r_prod;
    logic [63:0] r_sq;
    logic [32:0] r_speed;
    logic        r_moved;
    logic        r_ovalid;

    // Shared multiplier: 33-bit magnitude by 33-bit unsigned.
    logic [32:0] w_ma, w_mb;
    logic        w_neg;
    logic signed [31:0] w_op;
    logic [65:0] w_mp;
    vidc_pkg::t_dreq w_req;
    vidc_pkg::t_dres w_res;

    function automatic logic signed [31:0] f_round(input logic [65:0] p,
                                                   input logic [5:0] s,
                                                   input logic neg);
        logic [65:0] r;
        begin
            r = (p + (66'd1 << (s - 6'd1))) >> s;
            if (neg) f_round = (r >= 66'h80000000) ? 32'sh80000000 : -$signed(r[31:0]);
            else     f_round = (r >= 66'h80000000) ? 32'sh7fffffff : $signed(r[31:0]);
        end
    endfunction

    function automatic logic signed [31:0] f_sat(input logic signed [32:0] x);
        begin
            if (x > 33'sh07fffffff) f_sat = 32'sh7fffffff;
            else if (x < -33'sh080000000) f_sat = 32'sh80000000;
            else f_sat = x[31:0];
        end
    endfunction

    // The limit check squares max_speed and the clamp multiplies a velocity
    // magnitude by max_speed, both on the same multiplier.
    always_comb begin
        unique case (r_state)
            S_FMUL:  w_op = r_frc[r_ax];
            default: w_op = r_vel[r_ax];
        endcase
        w_neg = w_op[31];
        w_ma  = w_neg ? 33'(-{w_op[31], w_op}) : {1'b0, w_op};
        unique case (r_state)
            S_DRAG:  begin w_ma = {9'd0, r_drag}; w_mb = {17'd0, r_dt}; end
            S_DMUL:  w_mb = r_mult;
            S_SQ:    w_mb = w_ma;
            S_TEST:  begin w_ma = {2'd0, r_max}; w_mb = {2'd0, r_max}; end
            S_DIV:   w_mb = {2'd0, r_max};
            default: w_mb = {17'd0, r_dt};
        endcase
        w_mp = w_ma * w_mb;
    end

    always_comb begin
        w_req = '0;
        if (r_state == S_TEST && r_sq > vidc_pkg::EpsSq && r_sq > w_mp[63:0]) begin
            w_req.start   = 1'b1;
            w_req.is_sqrt = 1'b1;
            w_req.num     = r_sq;
        end else if (r_state == S_DIV && r_ph == 2'd1) begin
            w_req.start = 1'b1;
            w_req.num   = r_prod[63:0] + {32'd0, r_speed[32:1]};
            w_req.den   = r_speed;
        end
    end

    vidc_divsqrt u_ds (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_res   (w_res)
    );

    logic r_pneg;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_drag   <= '0;
            r_max    <= '1;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_vel[i] <= '0;
                r_frc[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    vidc_pkg::REG_DRAG: r_drag <= i_cfg_data[vidc_pkg::DragW-1:0];
                    vidc_pkg::REG_MAX:  r_max  <= i_cfg_data[vidc_pkg::MaxW-1:0];
                    default: ;
                endcase
            end
            if (r_state == S_OUT) r_ovalid <= 1'b1;
            else if (m_out.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (s_in.valid) begin
                        r_dt    <= s_in.data.time_step;
                        r_ax    <= '0;
                        r_moved <= 1'b0;
                        r_sq    <= '0;
                        for (int i = 0; i < 3; i++) r_mv[i] <= '0;
                        unique case (s_in.data.func)
                            vidc_pkg::FUNC_ADD_FORCE: begin
                                r_frc[0] <= f_sat(33'(r_frc[0]) + 33'(s_in.data.vec_x));
                                r_frc[1] <= f_sat(33'(r_frc[1]) + 33'(s_in.data.vec_y));
                                r_frc[2] <= f_sat(33'(r_frc[2]) + 33'(s_in.data.vec_z));
                                r_state  <= S_OUT;
                            end
                            vidc_pkg::FUNC_SET_VEL: begin
                                r_vel[0] <= s_in.data.vec_x;
                                r_vel[1] <= s_in.data.vec_y;
                                r_vel[2] <= s_in.data.vec_z;
                                r_state  <= S_OUT;
                            end
                            vidc_pkg::FUNC_TICK: r_state <= S_FMUL;
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_FMUL: begin
                    r_vel[r_ax] <= f_sat(33'(r_vel[r_ax]) + 33'(f_round(w_mp, 6'd16, w_neg)));
                    r_frc[r_ax] <= '0;
                    r_ax <= (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
                    if (r_ax == 2'd2) r_state <= S_DRAG;
                end
                S_DRAG: begin
                    r_mult  <= (w_mp[65:32] != 0) ? 33'd0 : 33'h100000000 - {1'b0, w_mp[31:0]};
                    r_state <= S_DMUL;
                end
                S_DMUL: begin
                    r_vel[r_ax] <= f_round(w_mp, 6'd32, w_neg);
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_sq <= r_sq + w_mp[63:0];
                    r_ax <= (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
                    r_state <= (r_ax == 2'd2) ? S_TEST : S_DMUL;
                end
                S_TEST: begin
                    if (r_sq <= vidc_pkg::EpsSq) begin
                        for (int i = 0; i < 3; i++) r_vel[i] <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_moved <= 1'b1;
                        r_state <= w_req.start ? S_SQRT : S_MMUL;
                    end
                end
                S_SQRT: begin
                    if (w_res.done) begin
                        r_speed <= w_res.res;
                        r_ph    <= 2'd0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    unique case (r_ph)
                        2'd0: begin
                            r_pneg <= w_neg;
                            r_prod <= w_mp;
                            r_ph <= 2'd1;
                        end
                        2'd1: r_ph <= 2'd2;
                        default: begin
                            if (w_res.done) begin
                                if (r_pneg) r_vel[r_ax] <= (w_res.res >= 33'h80000000)
                                    ? 32'sh80000000 : -$signed(w_res.res[31:0]);
                                else r_vel[r_ax] <= (w_res.res >= 33'h80000000)
                                    ? 32'sh7fffffff : $signed(w_res.res[31:0]);
                                r_ph <= 2'd0;
                                r_ax <= (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
                                if (r_ax == 2'd2) r_state <= S_MMUL;
                            end
                        end
                    endcase
                end
                S_MMUL: begin
                    r_mv[r_ax] <= f_round(w_mp, 6'd16, w_neg);
                    r_ax <= (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
                    if (r_ax == 2'd2) r_state <= S_OUT;
                end
                S_OUT: begin
                    r_state  <= S_WAIT;
                end
                default: begin
                    if (!r_ovalid || m_out.ready) r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_in.ready = (r_state == S_IDLE) && !r_ovalid;
    assign m_out.valid = r_ovalid;
    assign m_out.data.vel_x  = r_vel[0];
    assign m_out.data.vel_y  = r_vel[1];
    assign m_out.data.vel_z  = r_vel[2];
    assign m_out.data.move_x = r_mv[0];
    assign m_out.data.move_y = r_mv[1];
    assign m_out.data.move_z = r_mv[2];
    assign m_out.data.moved  = r_moved;
endmodule

### sv/vidc_divsqrt.sv
// Bit-serial restoring divider and integer square root, one result bit a cycle.
module vidc_divsqrt (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  vidc_pkg::t_dreq i_req,
    output vidc_pkg::t_dres o_res
);
    logic        r_busy;
    logic        r_sqrt;
    logic [6:0]  r_cnt;
    logic [63:0] r_num;
    logic [32:0] r_den;
    logic [65:0] r_rem;
    logic [32:0] r_q;
    logic        r_done;
    logic [65:0] n_rem_div;
    logic [65:0] n_rem_sq;
    logic [65:0] w_trial;

    always_comb begin
        n_rem_div = {r_rem[64:0], r_num[63]};
        n_rem_sq  = {r_rem[63:0], r_num[63:62]};
        w_trial   = r_sqrt ? {31'd0, r_q, 2'b01} : {33'd0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_sqrt <= i_req.is_sqrt;
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_q    <= '0;
                r_cnt  <= i_req.is_sqrt ? 7'd32 : 7'd64;
            end else if (r_busy) begin
                if (r_sqrt) begin
                    r_num <= {r_num[61:0], 2'b00};
                    if (n_rem_sq >= w_trial) begin
                        r_rem <= n_rem_sq - w_trial;
                        r_q   <= {r_q[31:0], 1'b1};
                    end else begin
                        r_rem <= n_rem_sq;
                        r_q   <= {r_q[31:0], 1'b0};
                    end
                end else begin
                    r_num <= {r_num[62:0], 1'b0};
                    if (n_rem_div >= w_trial) begin
                        r_rem <= n_rem_div - w_trial;
                        r_q   <= {r_q[31:0], 1'b1};
                    end else begin
                        r_rem <= n_rem_div;
                        r_q   <= {r_q[31:0], 1'b0};
                    end
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.res  = r_q;
endmodule

### bench/velocity_integrator_drag_clamp_test.sv
module velocity_integrator_drag_clamp_test;

    // Each stage runs random items under its own setting of sender and receiver idling.
    // Configuration is written between stages, while the block is idle.
    localparam int unsigned StallLimit = 20000;
    localparam int unsigned DrainWait  = 400;
    localparam int unsigned HoldCycles = 600;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [vidc_pkg::IdxW-1:0] i_cfg_idx;
    logic [vidc_pkg::CfgW-1:0] i_cfg_data;

    vidc_in_if  in_ch();
    vidc_out_if out_ch();

    velocity_integrator_drag_clamp DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_in       (in_ch.sink),
        .m_out      (out_ch.source)
    );

    // The predictor keeps its own copy of the block's state and registers.
    logic signed [63:0] vel_state [3];
    logic signed [63:0] force_state [3];
    logic [63:0]        drag_reg;
    logic [63:0]        max_reg;

    vidc_pkg::t_in  pending_items [$];
    vidc_pkg::t_out expected_results [$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          hold_armed;
    int unsigned hold_left;
    int unsigned offered_at;
    int unsigned error_count;
    int unsigned transfers_in;
    int unsigned transfers_out;
    int unsigned ticks_moved;
    int unsigned quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic signed [63:0] clip32(input logic signed [63:0] x);
        if (x > 64'sh7FFFFFFF) begin
            return 64'sh7FFFFFFF;
        end
        if (x < -64'sh80000000) begin
            return -64'sh80000000;
        end
        return x;
    endfunction

    // Product shifted down with rounding half away from zero, then saturated.
    function automatic logic signed [63:0] scale_round(input logic signed [63:0] a,
                                                       input logic [63:0] m,
                                                       input int unsigned s);
        logic [63:0] mag;
        logic [63:0] p;
        mag = (a < 0) ? 64'(-a) : 64'(a);
        p = (mag * m + (64'd1 << (s - 1))) >> s;
        if (p > 64'h1_0000_0000) begin
            p = 64'h1_0000_0000;
        end
        return clip32((a < 0) ? -$signed(p) : $signed(p));
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic vidc_pkg::t_out advance_motion(input vidc_pkg::t_in item);
        vidc_pkg::t_out res;
        logic signed [63:0] mv [3];
        logic [63:0] dt;
        logic [63:0] prod;
        logic [63:0] mult;
        logic [63:0] sq;
        logic [63:0] mag;
        logic [63:0] speed;
        logic [63:0] q;
        logic signed [63:0] vec [3];
        bit moved;
        vec[0] = item.vec_x;
        vec[1] = item.vec_y;
        vec[2] = item.vec_z;
        dt = 64'(item.time_step);
        moved = 1'b0;
        for (int i = 0; i < 3; i++) mv[i] = 0;
        case (vidc_pkg::t_func'(item.func))
            vidc_pkg::FUNC_ADD_FORCE: begin
                for (int i = 0; i < 3; i++) force_state[i] = clip32(force_state[i] + vec[i]);
            end
            vidc_pkg::FUNC_SET_VEL: begin
                for (int i = 0; i < 3; i++) vel_state[i] = vec[i];
            end
            vidc_pkg::FUNC_TICK: begin
                for (int i = 0; i < 3; i++) begin
                    vel_state[i] = clip32(vel_state[i] + scale_round(force_state[i], dt, 16));
                    force_state[i] = 0;
                end
                prod = drag_reg * dt;
                mult = (prod >= 64'h1_0000_0000) ? 64'd0 : 64'h1_0000_0000 - prod;
                sq = 0;
                for (int i = 0; i < 3; i++) begin
                    vel_state[i] = scale_round(vel_state[i], mult, 32);
                    mag = (vel_state[i] < 0) ? 64'(-vel_state[i]) : 64'(vel_state[i]);
                    sq = sq + mag * mag;
                end
                if (sq <= vidc_pkg::EpsSq) begin
                    for (int i = 0; i < 3; i++) vel_state[i] = 0;
                end else begin
                    moved = 1'b1;
                    if (sq > max_reg * max_reg) begin
                        speed = root_floor(sq);
                        for (int i = 0; i < 3; i++) begin
                            mag = (vel_state[i] < 0) ? 64'(-vel_state[i]) : 64'(vel_state[i]);
                            q = (mag * max_reg + speed / 2) / speed;
                            if (q > 64'h1_0000_0000) begin
                                q = 64'h1_0000_0000;
                            end
                            vel_state[i] = clip32((vel_state[i] < 0) ? -$signed(q) : $signed(q));
                        end
                    end
                    for (int i = 0; i < 3; i++) mv[i] = scale_round(vel_state[i], dt, 16);
                end
            end
            default: begin
            end
        endcase
        res.vel_x  = vel_state[0][31:0];
        res.vel_y  = vel_state[1][31:0];
        res.vel_z  = vel_state[2][31:0];
        res.move_x = mv[0][31:0];
        res.move_y = mv[1][31:0];
        res.move_z = mv[2][31:0];
        res.moved  = moved;
        return res;
    endfunction

    // Driver: offers the oldest pending item and keeps valid high until it is taken.
    // A transfer is recognised by the transfer count moving on since the offer.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || transfers_in != offered_at) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_ch.data  <= pending_items[0];
                in_ch.valid <= 1'b1;
            end else begin
                in_ch.valid <= 1'b0;
            end
            offered_at = transfers_in;
        end
    end

    // The driver drops the item from the queue at the edge where the transfer happens.
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            void'(pending_items.pop_front());
            expected_results.push_back(advance_motion(in_ch.data));
            transfers_in++;
        end
    end

    // Receiver: a long hold, once armed, is counted down here cycle by cycle.
    always @(negedge i_clk) begin
        if (hold_armed) begin
            hold_armed = 1'b0;
            hold_left  = HoldCycles;
        end
        if (!i_rst_n || hold_left != 0) begin
            out_ch.ready <= 1'b0;
            if (hold_left != 0) begin
                hold_left--;
            end
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: compares each result transfer field by field with the oldest expectation.
    always @(posedge i_clk) begin
        vidc_pkg::t_out want;
        vidc_pkg::t_out got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            transfers_out++;
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing expected");
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (want.moved) begin
                    ticks_moved++;
                end
                if (got.vel_x !== want.vel_x) begin
                    $error("vel_x expected %0d got %0d", want.vel_x, got.vel_x);
                    error_count++;
                end
                if (got.vel_y !== want.vel_y) begin
                    $error("vel_y expected %0d got %0d", want.vel_y, got.vel_y);
                    error_count++;
                end
                if (got.vel_z !== want.vel_z) begin
                    $error("vel_z expected %0d got %0d", want.vel_z, got.vel_z);
                    error_count++;
                end
                if (got.move_x !== want.move_x) begin
                    $error("move_x expected %0d got %0d", want.move_x, got.move_x);
                    error_count++;
                end
                if (got.move_y !== want.move_y) begin
                    $error("move_y expected %0d got %0d", want.move_y, got.move_y);
                    error_count++;
                end
                if (got.move_z !== want.move_z) begin
                    $error("move_z expected %0d got %0d", want.move_z, got.move_z);
                    error_count++;
                end
                if (got.moved !== want.moved) begin
                    $error("moved expected %0d got %0d", want.moved, got.moved);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither side completes a transfer.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= StallLimit) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic signed [31:0] rand_vec();
        case ($urandom_range(5))
            0: return 32'sh7FFFFFFF;
            1: return -32'sh80000000;
            2: return $signed(32'($urandom_range(2000)) - 32'sd1000);
            3: return $signed(32'($urandom_range(32'h0004_0000)) - 32'sh0002_0000);
            default: return $signed($urandom);
        endcase
    endfunction

    function automatic vidc_pkg::t_in make_item(input vidc_pkg::t_func f,
                                                input logic signed [31:0] x,
                                                input logic signed [31:0] y,
                                                input logic signed [31:0] z,
                                                input logic [15:0] dt);
        vidc_pkg::t_in it;
        it.func = f;
        it.vec_x = x;
        it.vec_y = y;
        it.vec_z = z;
        it.time_step = dt;
        return it;
    endfunction

    task automatic write_register(input logic [vidc_pkg::IdxW-1:0] idx,
                                  input logic [63:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[vidc_pkg::CfgW-1:0];
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == vidc_pkg::REG_DRAG) begin
            drag_reg = value & 64'hFF_FFFF;
        end else begin
            max_reg = value & 64'h7FFF_FFFF;
        end
    endtask

    task automatic wait_idle();
        wait (pending_items.size() == 0 && expected_results.size() == 0);
        repeat (DrainWait) @(posedge i_clk);
    endtask

    task automatic queue_random(input int unsigned count);
        vidc_pkg::t_func f;
        logic [15:0] dt;
        for (int unsigned n = 0; n < count; n++) begin
            // Mostly force and tick sequences so that drag and clamp are reached often.
            case ($urandom_range(9))
                0, 1, 2, 3: f = vidc_pkg::FUNC_ADD_FORCE;
                4, 5, 6: f = vidc_pkg::FUNC_TICK;
                7, 8: f = vidc_pkg::FUNC_SET_VEL;
                default: f = vidc_pkg::FUNC_NONE;
            endcase
            dt = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4000));
            pending_items.push_back(make_item(f, rand_vec(), rand_vec(), rand_vec(), dt));
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        in_ch.valid   = 1'b0;
        in_ch.data    = '0;
        out_ch.ready  = 1'b0;
        hold_armed    = 1'b0;
        hold_left     = 0;
        offered_at    = 0;
        send_idle_pct = 13;
        recv_idle_pct = 64;
        error_count   = 0;
        transfers_in  = 0;
        transfers_out = 0;
        ticks_moved   = 0;
        quiet_cycles  = 0;
        drag_reg      = 0;
        max_reg       = 64'h7FFF_FFFF;
        for (int i = 0; i < 3; i++) begin
            vel_state[i]   = 0;
            force_state[i] = 0;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part at reset settings: extremes, every function, and the small-speed cut-off.
        pending_items.push_back(make_item(vidc_pkg::FUNC_TICK, 0, 0, 0, 16'hFFFF));
        pending_items.push_back(make_item(vidc_pkg::FUNC_ADD_FORCE, 32'sh7FFFFFFF,
                                          -32'sh80000000, 32'sd5, 16'h0));
        pending_items.push_back(make_item(vidc_pkg::FUNC_ADD_FORCE, 32'sh7FFFFFFF,
                                          -32'sh80000000, -32'sd1, 16'hFFFF));
        pending_items.push_back(make_item(vidc_pkg::FUNC_TICK, 0, 0, 0, 16'hFFFF));
        pending_items.push_back(make_item(vidc_pkg::FUNC_SET_VEL, 32'sd20, -32'sd20, 32'sd10,
                                          16'h0));
        pending_items.push_back(make_item(vidc_pkg::FUNC_TICK, 32'sh7FFFFFFF, 0, 0, 16'd100));
        pending_items.push_back(make_item(vidc_pkg::FUNC_SET_VEL, 32'sd400, 32'sd300, 0,
                                          16'h0));
        pending_items.push_back(make_item(vidc_pkg::FUNC_TICK, 0, 0, 0, 16'd1));
        pending_items.push_back(make_item(vidc_pkg::FUNC_NONE, -32'sd1, -32'sd1, -32'sd1,
                                          16'hFFFF));
        pending_items.push_back(make_item(vidc_pkg::FUNC_SET_VEL, -32'sh80000000,
                                          -32'sh80000000, -32'sh80000000, 16'h0));
        pending_items.push_back(make_item(vidc_pkg::FUNC_TICK, 0, 0, 0, 16'h8000));
        wait_idle();

        // Zero speed limit and strong drag: with the long time step the drag multiplier saturates to zero.
        write_register(vidc_pkg::REG_MAX, 0);
        write_register(vidc_pkg::REG_DRAG, 64'hFF_FFFF);
        pending_items.push_back(make_item(vidc_pkg::FUNC_SET_VEL, 32'sh0010_0000, 0, 0,
                                          16'h0));
        pending_items.push_back(make_item(vidc_pkg::FUNC_TICK, 0, 0, 0, 16'h0000));
        pending_items.push_back(make_item(vidc_pkg::FUNC_SET_VEL, 32'sh0010_0000, 32'sh1, 0,
                                          16'h0));
        pending_items.push_back(make_item(vidc_pkg::FUNC_TICK, 0, 0, 0, 16'hFFFF));
        wait_idle();

        for (int stage = 0; stage < 3; stage++) begin
            case (stage)
                0: begin
                    send_idle_pct = 13;
                    recv_idle_pct = 64;
                end
                1: begin
                    send_idle_pct = 64;
                    recv_idle_pct = 13;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int part = 0; part < 3; part++) begin
                case (part)
                    0: begin
                        write_register(vidc_pkg::REG_DRAG, $urandom_range(32'h2_0000));
                        write_register(vidc_pkg::REG_MAX, $urandom_range(32'h0040_0000));
                    end
                    1: begin
                        write_register(vidc_pkg::REG_DRAG, 0);
                        write_register(vidc_pkg::REG_MAX, 64'h7FFF_FFFF);
                    end
                    default: begin
                        write_register(vidc_pkg::REG_DRAG, $urandom & 32'hFF_FFFF);
                        write_register(vidc_pkg::REG_MAX, $urandom & 32'h7FFF_FFFF);
                    end
                endcase
                queue_random(175);
                if (stage == 0 && part == 0) begin
                    // Hold the receiver off so that the block fills and stalls its input.
                    hold_armed = 1'b1;
                end
                wait_idle();
            end
        end

        $display("Covered %0d input and %0d result transfers, %0d ticks with a displacement.",
                 transfers_in, transfers_out, ticks_moved);
        $display("Drag and speed limit settings ran from zero to full scale over three idling mixes.");
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
